[sv/psg_pkg.sv]
// Shared widths, codes, control structs and level table for the PSG tone/noise generator.
`default_nettype none

package psg_pkg;

    localparam int BYTE_W     = 8;
    localparam int CPS_W      = 10;
    localparam int MASK_W     = 8;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int SEL_W      = 3;
    localparam int PERIOD_W   = 11;
    localparam int LEVEL_W    = 4;
    localparam int RATE_W     = 2;
    localparam int LFSR_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int MIX_W      = 18;
    localparam int NUM_TONES  = 3;
    localparam int NUM_CH     = 4;
    localparam int TONE_SEL_W = 2;
    localparam int DIV_W      = PERIOD_W;
    localparam int STEP_W     = $clog2(DIV_W);

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCKS_PER_SAMPLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MASK       = 1'd1;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [CPS_W-1:0]    CPS_RESET          = 10'd81;
    localparam logic [MASK_W-1:0]   MASK_RESET         = 8'hFF;
    localparam logic [PERIOD_W-1:0] TONE_PERIOD_RESET  = 11'd1024;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN         = 11'd2;
    localparam logic [LEVEL_W-1:0]  LEVEL_SILENT       = 4'd15;
    localparam logic [LFSR_W-1:0]   LFSR_SEED          = 16'h8000;
    localparam logic [1:0]          NOISE_CH           = 2'd3;
    localparam logic [TONE_SEL_W-1:0] TONE_LAST        = 2'd2;

    localparam logic [RATE_W-1:0]   RATE_16   = 2'd0;
    localparam logic [RATE_W-1:0]   RATE_32   = 2'd1;
    localparam logic [RATE_W-1:0]   RATE_64   = 2'd2;
    localparam logic [RATE_W-1:0]   RATE_TONE = 2'd3;
    localparam logic [PERIOD_W-1:0] NOISE_PER_16 = 11'h010;
    localparam logic [PERIOD_W-1:0] NOISE_PER_32 = 11'h020;
    localparam logic [PERIOD_W-1:0] NOISE_PER_64 = 11'h040;

    localparam logic signed [MIX_W-1:0] MIX_MAX = 18'sd32767;
    localparam logic signed [MIX_W-1:0] MIX_MIN = -18'sd32768;

    typedef struct packed {
        logic                  write_reg;
        logic                  clamp;
        logic                  div_load;
        logic                  div_step;
        logic                  div_store;
        logic                  noise_add;
        logic                  noise_step;
        logic                  load_out;
        logic [TONE_SEL_W-1:0] tone_sel;
    } psg_cmd_t;

    typedef struct packed {
        logic noise_more;
    } psg_status_t;

    // 2 dB attenuation steps, 15 is silent
    function automatic logic [SAMPLE_W-1:0] level_value(input logic [LEVEL_W-1:0] lvl);
        logic [SAMPLE_W-1:0] v;
        unique case (lvl)
            4'd0:  v = 16'd32767;
            4'd1:  v = 16'd26027;
            4'd2:  v = 16'd20674;
            4'd3:  v = 16'd16422;
            4'd4:  v = 16'd13044;
            4'd5:  v = 16'd10361;
            4'd6:  v = 16'd8230;
            4'd7:  v = 16'd6537;
            4'd8:  v = 16'd5193;
            4'd9:  v = 16'd4125;
            4'd10: v = 16'd3276;
            4'd11: v = 16'd2602;
            4'd12: v = 16'd2067;
            4'd13: v = 16'd1642;
            4'd14: v = 16'd1304;
            4'd15: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [MIX_W-1:0] signed_level(input logic phase,
                                                            input logic [LEVEL_W-1:0] lvl);
        logic signed [MIX_W-1:0] v;
        v = signed'({{(MIX_W-SAMPLE_W){1'b0}}, level_value(lvl)});
        return phase ? v : -v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] saturate(input logic signed [MIX_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > MIX_MAX)
        begin
            r = MIX_MAX[SAMPLE_W-1:0];
        end
        else if (v < MIX_MIN)
        begin
            r = MIX_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/psg_if.sv]
// Valid/ready channel interfaces for register/sample requests and stereo results.
`default_nettype none

interface psg_in_if;
    import psg_pkg::*;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] write_byte;

    modport source (output valid, output mode, output write_byte, input ready);
    modport sink   (input valid, input mode, input write_byte, output ready);
endinterface

interface psg_out_if;
    import psg_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

[sv/psg_div.sv]
// Restoring divider, one quotient bit per step; keeps remainder and quotient parity.
`default_nettype none

module psg_div (
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic                        step,
    input  wire logic [psg_pkg::DIV_W-1:0]   dividend,
    input  wire logic [psg_pkg::DIV_W-1:0]   divisor,
    output logic      [psg_pkg::DIV_W-1:0]   remainder,
    output logic                             parity
);
    import psg_pkg::*;

    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic             par_reg, par_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_W-1]};
        diff     = trial - {1'b0, divisor};
        fits     = (trial >= {1'b0, divisor});
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        par_next = par_reg;
        if (load)
        begin
            dvd_next = dividend;
            rem_next = '0;
            par_next = 1'b0;
        end
        else if (step)
        begin
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            // last step leaves the quotient LSB
            par_next = fits;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        par_reg <= par_next;
    end

    assign remainder = rem_reg;
    assign parity    = par_reg;

endmodule

`default_nettype wire

[sv/psg_dp.sv]
// Datapath: config and chip registers, tone division, noise LFSR and stereo mixer.
`default_nettype none

module psg_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [psg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [psg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [psg_pkg::BYTE_W-1:0]         write_byte,
    input  wire psg_pkg::psg_cmd_t                  cmd,
    output psg_pkg::psg_status_t                    status,
    output logic signed [psg_pkg::SAMPLE_W-1:0]     left_sample,
    output logic signed [psg_pkg::SAMPLE_W-1:0]     right_sample
);
    import psg_pkg::*;

    logic [CPS_W-1:0]    cps_reg;
    logic [MASK_W-1:0]   mask_reg;

    logic [SEL_W-1:0]    latch_sel_reg, latch_sel_next;
    logic [PERIOD_W-1:0] tone_period_reg [NUM_TONES];
    logic [PERIOD_W-1:0] tone_period_next [NUM_TONES];
    logic [LEVEL_W-1:0]  tone_level_reg [NUM_TONES];
    logic [LEVEL_W-1:0]  tone_level_next [NUM_TONES];
    logic [PERIOD_W-1:0] tone_count_reg [NUM_TONES];
    logic [PERIOD_W-1:0] tone_count_next [NUM_TONES];
    logic                tone_phase_reg [NUM_TONES];
    logic                tone_phase_next [NUM_TONES];
    logic [RATE_W-1:0]   noise_rate_reg, noise_rate_next;
    logic                noise_white_reg, noise_white_next;
    logic [LEVEL_W-1:0]  noise_level_reg, noise_level_next;
    logic [PERIOD_W-1:0] noise_count_reg, noise_count_next;
    logic [LFSR_W-1:0]   lfsr_reg, lfsr_next;

    logic signed [SAMPLE_W-1:0] left_reg, right_reg;

    logic [PERIOD_W-1:0] noise_per;
    logic [DIV_W-1:0]    dividend;
    logic [DIV_W-1:0]    remainder;
    logic                parity;
    logic                fb;
    logic [1:0]          wr_ch;
    logic [1:0]          lat_ch;

    logic signed [MIX_W-1:0] ch_val [NUM_CH];
    logic signed [MIX_W-1:0] left_sum, right_sum;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cps_reg  <= CPS_RESET;
            mask_reg <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLOCKS_PER_SAMPLE: cps_reg  <= cfg_data[CPS_W-1:0];
                CFG_STEREO_MASK:       mask_reg <= cfg_data[MASK_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (noise_rate_reg)
            RATE_16:   noise_per = NOISE_PER_16;
            RATE_32:   noise_per = NOISE_PER_32;
            RATE_64:   noise_per = NOISE_PER_64;
            RATE_TONE: noise_per = tone_period_reg[TONE_LAST];
        endcase
    end

    assign status.noise_more = (noise_count_reg >= noise_per);
    assign dividend = tone_count_reg[cmd.tone_sel] + {1'b0, cps_reg};
    assign fb       = noise_white_reg ? (lfsr_reg[0] ^ lfsr_reg[3]) : lfsr_reg[0];
    assign wr_ch    = write_byte[6:5];
    assign lat_ch   = latch_sel_reg[2:1];

    psg_div u_div (
        .clk       (clk),
        .load      (cmd.div_load),
        .step      (cmd.div_step),
        .dividend  (dividend),
        .divisor   (tone_period_reg[cmd.tone_sel]),
        .remainder (remainder),
        .parity    (parity)
    );

    always_comb
    begin
        latch_sel_next   = latch_sel_reg;
        tone_period_next = tone_period_reg;
        tone_level_next  = tone_level_reg;
        tone_count_next  = tone_count_reg;
        tone_phase_next  = tone_phase_reg;
        noise_rate_next  = noise_rate_reg;
        noise_white_next = noise_white_reg;
        noise_level_next = noise_level_reg;
        noise_count_next = noise_count_reg;
        lfsr_next        = lfsr_reg;

        if (cmd.write_reg)
        begin
            if (write_byte[7])
            begin
                latch_sel_next = write_byte[6:4];
                if (wr_ch != NOISE_CH)
                begin
                    if (write_byte[4])
                    begin
                        tone_level_next[wr_ch] = write_byte[3:0];
                    end
                    else
                    begin
                        tone_period_next[wr_ch] = {1'b0, tone_period_reg[wr_ch][9:4],
                                                   write_byte[3:0]};
                    end
                end
                else if (write_byte[4])
                begin
                    noise_level_next = write_byte[3:0];
                end
                else
                begin
                    noise_rate_next  = write_byte[1:0];
                    noise_white_next = write_byte[2];
                    lfsr_next        = LFSR_SEED;
                end
            end
            else if (lat_ch != NOISE_CH && !latch_sel_reg[0])
            begin
                tone_period_next[lat_ch] = {1'b0, write_byte[5:0],
                                            tone_period_reg[lat_ch][3:0]};
            end
        end

        if (cmd.clamp)
        begin
            for (int i = 0; i < NUM_TONES; i++)
            begin
                if (tone_period_reg[i] < PERIOD_MIN)
                begin
                    tone_period_next[i] = PERIOD_MIN;
                end
            end
        end

        if (cmd.div_store)
        begin
            tone_count_next[cmd.tone_sel] = remainder;
            tone_phase_next[cmd.tone_sel] = tone_phase_reg[cmd.tone_sel] ^ parity;
        end

        if (cmd.noise_add)
        begin
            noise_count_next = noise_count_reg + {1'b0, cps_reg};
        end

        if (cmd.noise_step)
        begin
            noise_count_next = noise_count_reg - noise_per;
            lfsr_next        = {fb, lfsr_reg[LFSR_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_sel_reg <= '0;
            for (int i = 0; i < NUM_TONES; i++)
            begin
                tone_period_reg[i] <= TONE_PERIOD_RESET;
                tone_level_reg[i]  <= LEVEL_SILENT;
                tone_count_reg[i]  <= '0;
                tone_phase_reg[i]  <= 1'b0;
            end
            noise_rate_reg  <= RATE_16;
            noise_white_reg <= 1'b0;
            noise_level_reg <= LEVEL_SILENT;
            noise_count_reg <= '0;
            lfsr_reg        <= LFSR_SEED;
        end
        else
        begin
            latch_sel_reg   <= latch_sel_next;
            tone_period_reg <= tone_period_next;
            tone_level_reg  <= tone_level_next;
            tone_count_reg  <= tone_count_next;
            tone_phase_reg  <= tone_phase_next;
            noise_rate_reg  <= noise_rate_next;
            noise_white_reg <= noise_white_next;
            noise_level_reg <= noise_level_next;
            noise_count_reg <= noise_count_next;
            lfsr_reg        <= lfsr_next;
        end
    end

    // stereo mix
    always_comb
    begin
        for (int i = 0; i < NUM_TONES; i++)
        begin
            ch_val[i] = signed_level(tone_phase_reg[i], tone_level_reg[i]);
        end
        ch_val[NUM_CH-1] = signed_level(lfsr_reg[0], noise_level_reg);
        left_sum  = '0;
        right_sum = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (mask_reg[i])
            begin
                left_sum = left_sum + ch_val[i];
            end
            if (mask_reg[i+NUM_CH])
            begin
                right_sum = right_sum + ch_val[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            left_reg  <= saturate(left_sum);
            right_reg <= saturate(right_sum);
        end
    end

    assign left_sample  = left_reg;
    assign right_sample = right_reg;

endmodule

`default_nettype wire

[sv/psg_ctrl.sv]
// Sequencer: register writes, tone division passes, noise shift loop, result beat.
`default_nettype none

module psg_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_mode,
    output logic                       in_ready,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    input  wire psg_pkg::psg_status_t  status,
    output psg_pkg::psg_cmd_t          cmd
);
    import psg_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CLAMP     = 3'd1;
    localparam logic [2:0] S_DIV_LOAD  = 3'd2;
    localparam logic [2:0] S_DIV_STEP  = 3'd3;
    localparam logic [2:0] S_DIV_STORE = 3'd4;
    localparam logic [2:0] S_NOISE_ADD = 3'd5;
    localparam logic [2:0] S_NOISE     = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

    logic [2:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [TONE_SEL_W-1:0] sel_reg, sel_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept;
    logic                  out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.tone_sel   = sel_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == MODE_SAMPLE)
                    begin
                        state_next = S_CLAMP;
                    end
                    else
                    begin
                        cmd.write_reg = 1'b1;
                    end
                end
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                sel_next   = '0;
                state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_DIV_STORE;
                end
            end
            S_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                if (sel_reg == TONE_LAST)
                begin
                    state_next = S_NOISE_ADD;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = S_DIV_LOAD;
                end
            end
            S_NOISE_ADD:
            begin
                cmd.noise_add = 1'b1;
                state_next    = S_NOISE;
            end
            S_NOISE:
            begin
                if (status.noise_more)
                begin
                    cmd.noise_step = 1'b1;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/psg_tone_noise_generator_top.sv]
// Top level of the PSG tone/noise generator: sequencer plus datapath.
// Register byte beat: applied at the edge that accepts it, no result beat.
// Sample beat: clamp, then the 11-step tone divider run three times, then the noise
//   LFSR loop, then the result register, plus any wait for the previous result to
//   drain; one sample in flight.
// Reset: chip registers to silent defaults, LFSR 0x8000, clocks-per-sample to CPS_RESET, mask 0xFF.
`default_nettype none

module psg_tone_noise_generator_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    psg_in_if.sink                                in_ch,
    psg_out_if.source                             out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [psg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [psg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import psg_pkg::*;

    psg_cmd_t    cmd;
    psg_status_t status;

    psg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_mode   (in_ch.mode),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .status    (status),
        .cmd       (cmd)
    );

    psg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .write_byte   (in_ch.write_byte),
        .cmd          (cmd),
        .status       (status),
        .left_sample  (out_ch.left_sample),
        .right_sample (out_ch.right_sample)
    );

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_ch.valid || out_ch.ready))
        else $error("result register loaded while previous beat pending");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.write_reg, cmd.clamp, cmd.div_load, cmd.div_step,
                  cmd.div_store, cmd.noise_add, cmd.noise_step, cmd.load_out}))
        else $error("more than one datapath command at once");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.mode) |=> !in_ch.ready)
        else $error("input taken while a sample is in progress");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && !in_ch.mode) |=> !cmd.load_out)
        else $error("register byte produced a result");

endmodule

`default_nettype wire
